[src/lpim_pkg.sv]
`default_nettype none
package lpim_pkg;

  // table geometry, slot count must be a power of two so the home slot is a mask
  localparam int unsigned SLOTS = 1024;
  localparam int unsigned IDX_W = $clog2(SLOTS);
  localparam int unsigned CNT_W = 11;

  localparam logic [31:0] HASH_MULT = 32'h9E37_79B1;

  // command codes
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_LOOKUP = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] synapse_key;
    logic [31:0] dendrite_value;
    logic [31:0] spine_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [31:0]      out_dendrite;
    logic [31:0]      out_spine;
    logic [CNT_W-1:0] stored_count;
  } out_item_t;

  typedef struct packed {
    logic        used;
    logic [31:0] key;
    logic [31:0] dendrite;
    logic [31:0] spine;
  } slot_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    slot_t            data;
  } tbl_wr_t;

endpackage
`default_nettype wire

[src/lpim_table.sv]
`default_nettype none
module lpim_table (
  input  wire logic                      clk,
  input  wire lpim_pkg::tbl_wr_t         wr,
  input  wire logic [lpim_pkg::IDX_W-1:0] rd_addr,
  output lpim_pkg::slot_t                rd_data
);
  import lpim_pkg::*;

  slot_t mem [SLOTS];
  slot_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

[src/lpim_hash.sv]
`default_nettype none
module lpim_hash (
  input  wire logic                       clk,
  input  wire logic                       load,
  input  wire logic [31:0]                key,
  output logic [lpim_pkg::IDX_W-1:0]      home_idx
);
  import lpim_pkg::*;

  logic [31:0] prod;
  logic [31:0] hash_r;

  // multiplicative hash, product kept modulo 2^32
  assign prod = key * HASH_MULT;

  always_ff @(posedge clk) begin
    if (load) begin
      hash_r <= prod;
    end
  end

  assign home_idx = hash_r[IDX_W-1:0];

endmodule
`default_nettype wire

[src/linear_probe_id_map_core.sv]
`default_nettype none
// open-addressed map from a 32-bit key to two 32-bit values, linear probing with
// wrap, one slot memory with a single read port probed one slot per cycle.
// after reset the block runs a clearing pass over all 1024 slots with busy high.
// a command word is taken when start is high and busy is low; its result word
// appears on out_item for exactly one cycle with out_valid high and cannot be
// held off. an accepted item passes through the issue state and then probes 1 to
// 1024 slots, one read per cycle of the slot memory, before the next can be
// taken; command 3 goes from the issue state back to idle. the result strobe
// lands in the same cycle busy drops. removal leaves no tombstone.
module linear_probe_id_map_core (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire lpim_pkg::in_item_t  in_item,
  output logic                     out_valid,
  output lpim_pkg::out_item_t      out_item
);
  import lpim_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_ISSUE = 4'b0100,
    S_PROBE = 4'b1000
  } state_t;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

  state_t            state_r, state_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;       // probe slot, also clear counter
  logic [IDX_W-1:0]  tries_r, tries_nxt;   // slots passed so far
  logic [CNT_W-1:0]  count_r, count_nxt;
  in_item_t          item_r;
  out_item_t         out_r, out_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic              accept;
  logic [IDX_W-1:0]  home_idx;
  logic [IDX_W-1:0]  next_idx;
  logic [IDX_W-1:0]  rd_addr;
  slot_t             rd_data;
  tbl_wr_t           wr;
  logic              hit;
  logic              last_try;

  assign accept   = start && (state_r == S_IDLE);
  assign next_idx = (idx_r == LAST_IDX) ? '0 : idx_r + 1'b1;
  assign hit      = rd_data.used && (rd_data.key == item_r.synapse_key);
  assign last_try = (tries_r == LAST_IDX);

  lpim_hash u_hash (
    .clk      (clk),
    .load     (accept),
    .key      (in_item.synapse_key),
    .home_idx (home_idx)
  );

  lpim_table u_table (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    tries_nxt     = tries_r;
    count_nxt     = count_r;
    out_nxt       = out_r;
    out_valid_nxt = 1'b0;
    wr            = '0;
    // speculative read of the following slot keeps one probe per cycle
    rd_addr       = next_idx;

    case (state_r)
      S_CLEAR: begin
        wr.en     = 1'b1;
        wr.addr   = idx_r;
        wr.data   = '0;
        idx_nxt   = next_idx;
        if (idx_r == LAST_IDX) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (start) begin
          state_nxt = S_ISSUE;
        end
      end

      S_ISSUE: begin
        rd_addr   = home_idx;
        idx_nxt   = home_idx;
        tries_nxt = '0;
        if (item_r.command == CMD_INSERT || item_r.command == CMD_REMOVE ||
            item_r.command == CMD_LOOKUP) begin
          state_nxt = S_PROBE;
        end else begin
          // unused command, nothing changes
          out_nxt       = '{ST_NOT_FOUND, 32'd0, 32'd0, count_r};
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      S_PROBE: begin
        if (item_r.command == CMD_INSERT) begin
          if (!rd_data.used || hit) begin
            // fill a free slot or update the matching one
            wr.en   = 1'b1;
            wr.addr = idx_r;
            wr.data = '{1'b1, item_r.synapse_key, item_r.dendrite_value,
                        item_r.spine_value};
            if (!rd_data.used) begin
              count_nxt = count_r + 1'b1;
            end
            out_nxt       = '{ST_OK, 32'd0, 32'd0, count_nxt};
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end else if (last_try) begin
            out_nxt       = '{ST_FULL, 32'd0, 32'd0, count_r};
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end else begin
            idx_nxt   = next_idx;
            tries_nxt = tries_r + 1'b1;
          end
        end else begin
          // remove or lookup, chain ends at the first free slot
          if (hit) begin
            if (item_r.command == CMD_REMOVE) begin
              wr.en   = 1'b1;
              wr.addr = idx_r;
              wr.data = '{1'b0, rd_data.key, rd_data.dendrite, rd_data.spine};
              if (count_r != '0) begin
                count_nxt = count_r - 1'b1;
              end
              out_nxt = '{ST_OK, 32'd0, 32'd0, count_nxt};
            end else begin
              out_nxt = '{ST_OK, rd_data.dendrite, rd_data.spine, count_r};
            end
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end else if (!rd_data.used || last_try) begin
            out_nxt       = '{ST_NOT_FOUND, 32'd0, 32'd0, count_r};
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end else begin
            idx_nxt   = next_idx;
            tries_nxt = tries_r + 1'b1;
          end
        end
      end

      default: begin
        state_nxt = S_CLEAR;
        idx_nxt   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      idx_r       <= '0;
      tries_r     <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      tries_r     <= tries_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_item;
    end
    out_r <= out_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule
`default_nettype wire

[src/lpim_checker.sv]
`default_nettype none
module lpim_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                start,
  input wire logic                busy,
  input wire logic                out_valid,
  input wire lpim_pkg::out_item_t out_item
);
  import lpim_pkg::*;

  // a result strobe lasts one cycle
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // an accepted word keeps the block busy for at least the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("block not busy after accepting a word");

  // results only come out once the block is free again
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result while busy");

  // values are zero whenever the status reports a failure
  a_zero_values: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status != ST_OK) |->
      (out_item.out_dendrite == 32'd0 && out_item.out_spine == 32'd0))
    else $error("nonzero values with a failing status");

  // count never exceeds the slot total
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.stored_count <= CNT_W'(SLOTS)))
    else $error("stored count beyond table size");

endmodule

bind linear_probe_id_map_core lpim_checker u_lpim_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_item  (out_item)
);
`default_nettype wire

[verif/id_map_monitor.sv]
module id_map_monitor (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic                busy,
  input  wire lpim_pkg::in_item_t  in_item,
  input  wire logic                out_valid,
  input  wire lpim_pkg::out_item_t out_item,
  output int                       fail_count,
  output int                       pending,
  output int                       words_in,
  output int                       words_out,
  output int                       full_seen,
  output int                       miss_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import lpim_pkg::*;

  // shadow copy of the slot table
  bit          tbl_used [SLOTS];
  logic [31:0] tbl_key [SLOTS];
  logic [31:0] tbl_dend [SLOTS];
  logic [31:0] tbl_spine [SLOTS];
  int unsigned live_entries;

  out_item_t answer_q [$];
  out_item_t due;
  logic      wrong;

  initial begin
    live_entries = 0;
    fail_count = 0;
    pending = 0;
    words_in = 0;
    words_out = 0;
    full_seen = 0;
    miss_seen = 0;
  end

  // updates the shadow table and returns the answer word the command must give
  function automatic out_item_t apply_command(in_item_t w);
    out_item_t   r;
    logic [31:0] h;
    int unsigned idx;
    int unsigned tries;
    bit          hit;
    r = '0;
    r.status = ST_NOT_FOUND;
    h = w.synapse_key * HASH_MULT;
    idx = h % SLOTS;
    tries = 0;
    hit = 1'b0;
    case (w.command)
      CMD_INSERT: begin
        while (tbl_used[idx] && tbl_key[idx] != w.synapse_key && tries < SLOTS) begin
          idx = (idx + 1) % SLOTS;
          tries++;
        end
        if (tries >= SLOTS) begin
          r.status = ST_FULL;
        end else begin
          if (!tbl_used[idx]) live_entries++;
          tbl_used[idx] = 1'b1;
          tbl_key[idx] = w.synapse_key;
          tbl_dend[idx] = w.dendrite_value;
          tbl_spine[idx] = w.spine_value;
          r.status = ST_OK;
        end
      end
      CMD_REMOVE, CMD_LOOKUP: begin
        // stops at the first free slot, no tombstones
        while (!hit && tries < SLOTS && tbl_used[idx]) begin
          if (tbl_key[idx] == w.synapse_key) begin
            hit = 1'b1;
          end else begin
            idx = (idx + 1) % SLOTS;
            tries++;
          end
        end
        if (hit) begin
          r.status = ST_OK;
          if (w.command == CMD_REMOVE) begin
            tbl_used[idx] = 1'b0;
            if (live_entries > 0) live_entries--;
          end else begin
            r.out_dendrite = tbl_dend[idx];
            r.out_spine = tbl_spine[idx];
          end
        end
      end
      default: ;
    endcase
    r.stored_count = live_entries[CNT_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      // result word first, it always belongs to an earlier command word
      if (out_valid) begin
        words_out++;
        if (answer_q.size() == 0) begin
          if (fail_count < 10)
            $display("result word %0d arrived with nothing outstanding", words_out);
          fail_count++;
        end else begin
          due = answer_q.pop_front();
          wrong = (out_item.status !== due.status) ||
                  (out_item.out_dendrite !== due.out_dendrite) ||
                  (out_item.out_spine !== due.out_spine) ||
                  (out_item.stored_count !== due.stored_count);
          if (wrong) begin
            if (fail_count < 10) begin
              $write("mismatch on result word %0d (expected/actual): ", words_out);
              $display("status %0d/%0d dendrite %h/%h spine %h/%h count %0d/%0d",
                       due.status, out_item.status,
                       due.out_dendrite, out_item.out_dendrite,
                       due.out_spine, out_item.out_spine,
                       due.stored_count, out_item.stored_count);
            end
            fail_count++;
          end
          if (due.status == ST_FULL) full_seen++;
          if (due.status == ST_NOT_FOUND) miss_seen++;
        end
      end
      if (start && !busy) begin
        answer_q.push_back(apply_command(in_item));
        words_in++;
      end
      pending = answer_q.size();
    end
  end

endmodule

[verif/testbench.sv]
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import lpim_pkg::*;

  // the one code the package leaves unnamed, the block answers it as not found
  localparam logic [1:0]  CMD_UNUSED   = 2'd3;
  // slowest legal run is every word probing the whole table, taken several times
  localparam int unsigned CYCLE_LIMIT  = 8_000_000;
  // quiet time after the last answer, one full probe and some margin
  localparam int unsigned DRAIN_CYCLES = SLOTS + 64;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  in_item_t  in_item = '0;
  logic      busy;
  logic      out_valid;
  out_item_t out_item;

  int fail_count;
  int pending;
  int words_in;
  int words_out;
  int full_seen;
  int miss_seen;

  // chance in percent that the sender holds a cycle off before a word
  int unsigned idle_pct = 13;
  int unsigned cycles = 0;

  // keys sent with insert, reused so removes and lookups mostly hit
  logic [31:0] known_keys [SLOTS];
  int          known_n = 0;
  int          known_wr = 0;

  always #2 clk = ~clk;

  linear_probe_id_map_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  id_map_monitor scoreboard (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_item   (out_item),
    .fail_count (fail_count),
    .pending    (pending),
    .words_in   (words_in),
    .words_out  (words_out),
    .full_seen  (full_seen),
    .miss_seen  (miss_seen)
  );

  // watchdog, also covers the clearing pass after reset
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // present one command word and hold it until the block takes it
  task automatic send_word(input logic [1:0] cmd, input logic [31:0] key,
                           input logic [31:0] dval, input logic [31:0] sval);
    in_item_t w;
    w.command = cmd;
    w.synapse_key = key;
    w.dendrite_value = dval;
    w.spine_value = sval;
    // random sender gaps, each one a whole cycle with start low
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_item <= w;
    @(posedge clk);
    // busy seen here is its value at the edge, so a low one means taken
    while (busy) @(posedge clk);
    if (cmd == CMD_INSERT) begin
      known_keys[known_wr] = key;
      known_wr = (known_wr + 1) % SLOTS;
      if (known_n < SLOTS) known_n++;
    end
  endtask

  // new key, often from a few crowded home slots so chains form
  function automatic logic [31:0] fresh_key();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return ($urandom() << IDX_W) | $urandom_range(0, 7);
    if (r < 46) return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
    return $urandom();
  endfunction

  function automatic logic [31:0] pick_key();
    if (known_n > 0 && $urandom_range(0, 99) < 60)
      return known_keys[$urandom_range(0, known_n - 1)];
    return fresh_key();
  endfunction

  // random command mix, percentages for insert, remove and lookup, rest unused code
  task automatic run_mix(input int n, input int unsigned p_ins, input int unsigned p_rem,
                         input int unsigned p_look);
    int unsigned r;
    logic [1:0]  cmd;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < p_ins) cmd = CMD_INSERT;
      else if (r < p_ins + p_rem) cmd = CMD_REMOVE;
      else if (r < p_ins + p_rem + p_look) cmd = CMD_LOOKUP;
      else cmd = CMD_UNUSED;
      send_word(cmd, pick_key(), $urandom(), $urandom());
    end
  endtask

  initial begin
    logic [31:0] prod;
    logic [31:0] wrap_low;
    logic [31:0] c1;
    logic [31:0] c2;
    logic [31:0] c3;
    logic [31:0] first_fill;
    logic [31:0] key;

    // low key bits whose home is the last slot, chains from there wrap to slot 0
    wrap_low = '0;
    for (int k = 0; k < SLOTS; k++) begin
      prod = k * HASH_MULT;
      if (prod % SLOTS == SLOTS - 1) wrap_low = k;
    end
    c1 = (32'd1 << IDX_W) | wrap_low;
    c2 = (32'd2 << IDX_W) | wrap_low;
    c3 = (32'hFFFF_FFFF << IDX_W) | wrap_low;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed words, sender idles 13 percent
    idle_pct = 13;
    send_word(CMD_LOOKUP, 32'h0, 32'h0, 32'h0);                 // empty table miss
    send_word(CMD_REMOVE, 32'hFFFF_FFFF, 32'h0, 32'h0);         // remove miss
    send_word(CMD_INSERT, 32'h0, 32'h0, 32'h0);                 // all-zero entry
    send_word(CMD_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(CMD_LOOKUP, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(CMD_LOOKUP, 32'hFFFF_FFFF, 32'h0, 32'h0);
    send_word(CMD_INSERT, 32'h0, 32'hA5A5_A5A5, 32'h5A5A_5A5A); // update in place
    send_word(CMD_LOOKUP, 32'h0, 32'h0, 32'h0);
    send_word(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // one chain from the last slot, wraps past the key sitting in slot 0
    send_word(CMD_INSERT, c1, 32'h1111_1111, 32'h2222_2222);
    send_word(CMD_INSERT, c2, 32'h3333_3333, 32'h4444_4444);
    send_word(CMD_INSERT, c3, 32'h5555_5555, 32'h6666_6666);
    send_word(CMD_LOOKUP, c3, 32'h0, 32'h0);
    // removing the head leaves the rest of the chain unreachable
    send_word(CMD_REMOVE, c1, 32'h0, 32'h0);
    send_word(CMD_LOOKUP, c2, 32'h0, 32'h0);
    send_word(CMD_LOOKUP, c3, 32'h0, 32'h0);
    // reinsert lands in the freed head slot, the stale copy still counts
    send_word(CMD_INSERT, c2, 32'h7777_7777, 32'h8888_8888);
    send_word(CMD_LOOKUP, c2, 32'h0, 32'h0);
    send_word(CMD_REMOVE, c2, 32'h0, 32'h0);
    send_word(CMD_LOOKUP, c2, 32'h0, 32'h0);
    send_word(CMD_REMOVE, 32'h0, 32'h0, 32'h0);
    send_word(CMD_LOOKUP, 32'h0, 32'h0, 32'h0);

    // light load random mix
    run_mix(320, 45, 20, 30);

    // sender idles 48 percent: fill every home slot, late ones find the table full
    idle_pct = 48;
    first_fill = '0;
    for (int i = 0; i < SLOTS; i++) begin
      key = ($urandom() << IDX_W) | i;
      if (i == 0) first_fill = key;
      send_word(CMD_INSERT, key, $urandom(), $urandom());
    end
    send_word(CMD_INSERT, first_fill, 32'hFFFF_FFFF, 32'h0);   // update while full
    send_word(CMD_LOOKUP, first_fill, 32'h0, 32'h0);
    send_word(CMD_INSERT, fresh_key(), $urandom(), $urandom()); // no room
    send_word(CMD_LOOKUP, $urandom(), 32'h0, 32'h0);            // probes every slot
    send_word(CMD_REMOVE, $urandom(), 32'h0, 32'h0);
    // drain from full, removes dominate
    run_mix(250, 15, 50, 30);

    // back to back words, no sender gaps
    idle_pct = 0;
    run_mix(200, 35, 30, 30);
    start <= 1'b0;

    // all answers in, then quiet time to catch stray result words
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);

    $display("sent %0d command words, got %0d result words; %0d full and %0d not found answers",
             words_in, words_out, full_seen, miss_seen);
    $display("covered wrapped chains, removal without tombstones and a completely full table");
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d failures, %0d answers never arrived", fail_count, pending);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
